>>> rtl/squaring_mod_random_bytes_defines.svh
// ----------------------------------------------------------------------------
// Squaring-mod random bytes: assertion macros
// Concurrent assertion shorthands used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SQUARING_MOD_RANDOM_BYTES_DEFINES_SVH
`define SQUARING_MOD_RANDOM_BYTES_DEFINES_SVH

// same-cycle implication
`define SQMRB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SQMRB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/sqmrb_pkg.sv
// ----------------------------------------------------------------------------
// Squaring-mod random bytes: package
// Constants, microcode control word and program ROM for the sequencer.
// ----------------------------------------------------------------------------
package sqmrb_pkg;

    localparam int FUNC_W   = 2;
    localparam int DCNT_W   = 16;
    localparam int SEED_W   = 32;
    localparam int BYTE_W   = 8;
    localparam int MOD_W    = 24;
    localparam int MUL_W    = 25;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int X_W      = 48;
    localparam int D_W      = 26;
    localparam int CORR_W   = 27;
    localparam int PC_W     = 4;

    localparam logic [MOD_W-1:0]  SQ_MOD     = 24'd12637769;
    localparam logic [CORR_W-1:0] SQ_MOD2    = 27'd25275538;
    localparam logic [MUL_W-1:0]  BRT_MU     = 25'd22272521;
    localparam logic [SEED_W-1:0] SEED_RESET = 32'd2014;

    localparam logic [FUNC_W-1:0] FN_GET        = 2'd0;
    localparam logic [FUNC_W-1:0] FN_GET_KERNEL = 2'd1;
    localparam logic [FUNC_W-1:0] FN_DISCARD    = 2'd2;

    localparam logic ST_OK     = 1'b0;
    localparam logic ST_DENIED = 1'b1;

    localparam logic [PC_W-1:0] PC_START = 4'd0;
    localparam logic [PC_W-1:0] PC_SQ    = 4'd5;
    localparam logic [PC_W-1:0] PC_DONE  = 4'd10;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_MULMU,
        OP_MULM,
        OP_SUB,
        OP_CORR,
        OP_CORRSV,
        OP_SQ,
        OP_DONE
    } t_op;

    typedef enum logic [1:0] {
        J_NONE,
        J_LT_MOD,
        J_MORE
    } t_jmp;

    typedef struct packed {
        t_op             op;
        t_jmp            jmp;
        logic [PC_W-1:0] target;
    } t_uword;

    typedef struct packed {
        t_op  op;
        logic seed_we;
    } t_dp_ctl;

    typedef struct packed {
        logic lt_mod;
    } t_dp_sts;

    function automatic t_uword f_ucode(input logic [PC_W-1:0] pc);
        t_uword uw;
        unique case (pc)
            4'd0:    uw = '{op: OP_LOAD,   jmp: J_LT_MOD, target: PC_SQ};
            4'd1:    uw = '{op: OP_MULMU,  jmp: J_NONE,   target: PC_START};
            4'd2:    uw = '{op: OP_MULM,   jmp: J_NONE,   target: PC_START};
            4'd3:    uw = '{op: OP_SUB,    jmp: J_NONE,   target: PC_START};
            4'd4:    uw = '{op: OP_CORR,   jmp: J_NONE,   target: PC_START};
            4'd5:    uw = '{op: OP_SQ,     jmp: J_NONE,   target: PC_START};
            4'd6:    uw = '{op: OP_MULMU,  jmp: J_NONE,   target: PC_START};
            4'd7:    uw = '{op: OP_MULM,   jmp: J_NONE,   target: PC_START};
            4'd8:    uw = '{op: OP_SUB,    jmp: J_NONE,   target: PC_START};
            4'd9:    uw = '{op: OP_CORRSV, jmp: J_MORE,   target: PC_SQ};
            default: uw = '{op: OP_DONE,   jmp: J_NONE,   target: PC_START};
        endcase
        return uw;
    endfunction

endpackage

>>> rtl/sqmrb_ifs.sv
// ----------------------------------------------------------------------------
// Squaring-mod random bytes: channel interfaces
// Request, response and seed-write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface sqmrb_req_if;
    logic                         valid;
    logic                         ready;
    logic [sqmrb_pkg::FUNC_W-1:0] func;
    logic                         from_user;
    logic [sqmrb_pkg::DCNT_W-1:0] discard_count;
    logic                         last;

    modport source (output valid, func, from_user, discard_count, last, input ready);
    modport sink   (input valid, func, from_user, discard_count, last, output ready);
endinterface

interface sqmrb_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [sqmrb_pkg::BYTE_W-1:0] random_byte;
    logic                         byte_valid;
    logic                         status;
    logic                         last_out;

    modport source (output valid, random_byte, byte_valid, status, last_out, input ready);
    modport sink   (input valid, random_byte, byte_valid, status, last_out, output ready);
endinterface

interface sqmrb_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [sqmrb_pkg::SEED_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

>>> rtl/squaring_mod_random_bytes.sv
// Byte request: the squaring loop runs twice per byte; a seed at or above the
// modulus first needs an extra reduction; a discard runs it twice per discarded byte.
// Refused, zero-count and unused requests go straight to the done step.
// One request in flight: the next beat is taken once the result is registered, which
// waits while a stalled result is held; the squaring loop uses the shared multiplier.
// Synchronous active-low reset: generator value 2014, sequencer idle, no result.
// ----------------------------------------------------------------------------
// Squaring-mod random bytes: top level
// Microcoded sequencer driving a modular-squaring datapath; seed write port.
// ----------------------------------------------------------------------------
module squaring_mod_random_bytes #(
    parameter int COUNT_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sqmrb_cfg_if.sink    i_cfg,
    sqmrb_req_if.sink    i_req,
    sqmrb_rsp_if.source  o_rsp
);

    localparam int CW    = (COUNT_BITS < sqmrb_pkg::DCNT_W) ? COUNT_BITS : sqmrb_pkg::DCNT_W;
    localparam int CNT_W = CW + 1;

    sqmrb_pkg::t_state r_state, n_state;
    logic [sqmrb_pkg::PC_W-1:0]   r_pc, n_pc;
    logic [CNT_W-1:0]             r_cnt, n_cnt;
    logic                         r_byte_ok, n_byte_ok;
    logic                         r_denied, n_denied;
    logic                         r_last, n_last;
    logic                         r_out_valid, n_out_valid;
    logic [sqmrb_pkg::BYTE_W-1:0] r_out_byte, n_out_byte;
    logic                         r_out_ok, n_out_ok;
    logic                         r_out_status, n_out_status;
    logic                         r_out_last, n_out_last;

    sqmrb_pkg::t_uword            w_uw;
    sqmrb_pkg::t_dp_ctl           w_ctl;
    sqmrb_pkg::t_dp_sts           w_sts;
    logic [sqmrb_pkg::BYTE_W-1:0] w_byte;
    logic [CW-1:0]                w_count;

    assign w_uw    = sqmrb_pkg::f_ucode(r_pc);
    assign w_count = i_req.discard_count[CW-1:0];

    sqmrb_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_seed  (i_cfg.data),
        .o_sts   (w_sts),
        .o_byte  (w_byte)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sqmrb_pkg::ST_IDLE;
            r_pc        <= sqmrb_pkg::PC_START;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pc        <= n_pc;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt        <= n_cnt;
        r_byte_ok    <= n_byte_ok;
        r_denied     <= n_denied;
        r_last       <= n_last;
        r_out_byte   <= n_out_byte;
        r_out_ok     <= n_out_ok;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

    always_comb begin
        n_state      = r_state;
        n_pc         = r_pc;
        n_cnt        = r_cnt;
        n_byte_ok    = r_byte_ok;
        n_denied     = r_denied;
        n_last       = r_last;
        n_out_valid  = r_out_valid;
        n_out_byte   = r_out_byte;
        n_out_ok     = r_out_ok;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        w_ctl.op      = sqmrb_pkg::OP_NOP;
        w_ctl.seed_we = i_cfg.valid && i_cfg.ready;

        if (o_rsp.valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            sqmrb_pkg::ST_IDLE: begin
                if (i_req.valid) begin
                    n_state   = sqmrb_pkg::ST_RUN;
                    n_last    = i_req.last;
                    n_denied  = (i_req.func == sqmrb_pkg::FN_GET_KERNEL) && i_req.from_user;
                    n_byte_ok = (i_req.func == sqmrb_pkg::FN_GET)
                             || ((i_req.func == sqmrb_pkg::FN_GET_KERNEL) && !i_req.from_user);
                    if (n_byte_ok) begin
                        n_cnt = CNT_W'(2);
                        n_pc  = sqmrb_pkg::PC_START;
                    end else if ((i_req.func == sqmrb_pkg::FN_DISCARD) && (w_count != '0)) begin
                        n_cnt = {w_count, 1'b0};
                        n_pc  = sqmrb_pkg::PC_START;
                    end else begin
                        n_pc  = sqmrb_pkg::PC_DONE;
                    end
                end
            end
            sqmrb_pkg::ST_RUN: begin
                if (w_uw.op == sqmrb_pkg::OP_DONE) begin
                    if (!r_out_valid || o_rsp.ready) begin
                        n_out_valid  = 1'b1;
                        n_out_byte   = r_byte_ok ? w_byte : '0;
                        n_out_ok     = r_byte_ok;
                        n_out_status = r_denied ? sqmrb_pkg::ST_DENIED : sqmrb_pkg::ST_OK;
                        n_out_last   = r_last;
                        n_state      = sqmrb_pkg::ST_IDLE;
                    end
                end else begin
                    w_ctl.op = w_uw.op;
                    n_pc     = r_pc + sqmrb_pkg::PC_W'(1);
                    unique case (w_uw.jmp)
                        sqmrb_pkg::J_LT_MOD: begin
                            if (w_sts.lt_mod) begin
                                n_pc = w_uw.target;
                            end
                        end
                        sqmrb_pkg::J_MORE: begin
                            if (r_cnt != CNT_W'(1)) begin
                                n_pc = w_uw.target;
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (w_uw.op == sqmrb_pkg::OP_CORRSV) begin
                        n_cnt = r_cnt - CNT_W'(1);
                    end
                end
            end
            default: begin
                n_state = sqmrb_pkg::ST_IDLE;
            end
        endcase
    end

    assign i_req.ready       = (r_state == sqmrb_pkg::ST_IDLE);
    assign i_cfg.ready       = (r_state == sqmrb_pkg::ST_IDLE);
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.random_byte = r_out_byte;
    assign o_rsp.byte_valid  = r_out_ok;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.last_out    = r_out_last;

endmodule

>>> rtl/sqmrb_dp.sv
// ----------------------------------------------------------------------------
// Squaring-mod random bytes: datapath
// Generator value, one shared 25x25 multiplier and Barrett reduction stages.
// ----------------------------------------------------------------------------
module sqmrb_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  sqmrb_pkg::t_dp_ctl           i_ctl,
    input  logic [sqmrb_pkg::SEED_W-1:0] i_seed,
    output sqmrb_pkg::t_dp_sts           o_sts,
    output logic [sqmrb_pkg::BYTE_W-1:0] o_byte
);

    logic [sqmrb_pkg::SEED_W-1:0] r_v;
    logic [sqmrb_pkg::X_W-1:0]    r_x;
    logic [sqmrb_pkg::PROD_W-1:0] r_p;
    logic [sqmrb_pkg::D_W-1:0]    r_d;
    logic [sqmrb_pkg::MOD_W-1:0]  r_r;
    logic [sqmrb_pkg::BYTE_W-1:0] r_b;

    logic [sqmrb_pkg::MUL_W-1:0]  w_a;
    logic [sqmrb_pkg::MUL_W-1:0]  w_bm;
    logic [sqmrb_pkg::PROD_W-1:0] w_prod;
    logic [sqmrb_pkg::CORR_W-1:0] w_d1;
    logic [sqmrb_pkg::CORR_W-1:0] w_d2;
    logic [sqmrb_pkg::MOD_W-1:0]  w_corr;

    always_comb begin
        unique case (i_ctl.op) inside
            sqmrb_pkg::OP_MULMU: begin
                w_a  = r_x[sqmrb_pkg::X_W-1 -: sqmrb_pkg::MUL_W];
                w_bm = sqmrb_pkg::BRT_MU;
            end
            sqmrb_pkg::OP_MULM: begin
                w_a  = r_p[sqmrb_pkg::PROD_W-1 -: sqmrb_pkg::MUL_W];
                w_bm = {1'b0, sqmrb_pkg::SQ_MOD};
            end
            sqmrb_pkg::OP_SQ: begin
                w_a  = {1'b0, r_r};
                w_bm = {1'b0, r_r};
            end
            default: begin
                w_a  = '0;
                w_bm = '0;
            end
        endcase
    end

    assign w_prod = w_a * w_bm;

    // bring a Barrett remainder in [0, 3M) down to [0, M)
    assign w_d1 = {1'b0, r_d} - {3'b000, sqmrb_pkg::SQ_MOD};
    assign w_d2 = {1'b0, r_d} - sqmrb_pkg::SQ_MOD2;

    always_comb begin
        if (!w_d2[sqmrb_pkg::CORR_W-1]) begin
            w_corr = w_d2[sqmrb_pkg::MOD_W-1:0];
        end else if (!w_d1[sqmrb_pkg::CORR_W-1]) begin
            w_corr = w_d1[sqmrb_pkg::MOD_W-1:0];
        end else begin
            w_corr = r_d[sqmrb_pkg::MOD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= sqmrb_pkg::SEED_RESET;
        end else if (i_ctl.seed_we) begin
            r_v <= i_seed;
        end else if (i_ctl.op == sqmrb_pkg::OP_CORRSV) begin
            r_v <= {{(sqmrb_pkg::SEED_W-sqmrb_pkg::MOD_W){1'b0}}, w_corr};
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_ctl.op) inside
            sqmrb_pkg::OP_LOAD: begin
                r_x <= {{(sqmrb_pkg::X_W-sqmrb_pkg::SEED_W){1'b0}}, r_v};
                r_r <= r_v[sqmrb_pkg::MOD_W-1:0];
            end
            sqmrb_pkg::OP_MULMU, sqmrb_pkg::OP_MULM: begin
                r_p <= w_prod;
            end
            sqmrb_pkg::OP_SQ: begin
                r_x <= w_prod[sqmrb_pkg::X_W-1:0];
            end
            sqmrb_pkg::OP_SUB: begin
                r_d <= r_x[sqmrb_pkg::D_W-1:0] - r_p[sqmrb_pkg::D_W-1:0];
            end
            sqmrb_pkg::OP_CORR: begin
                r_r <= w_corr;
            end
            sqmrb_pkg::OP_CORRSV: begin
                r_r <= w_corr;
                r_b <= {w_corr[3:0], r_b[sqmrb_pkg::BYTE_W-1:4]};
            end
            default: begin
            end
        endcase
    end

    assign o_sts.lt_mod = (r_v < {{(sqmrb_pkg::SEED_W-sqmrb_pkg::MOD_W){1'b0}}, sqmrb_pkg::SQ_MOD});
    assign o_byte       = r_b;

endmodule

>>> rtl/sqmrb_checker.sv
// ----------------------------------------------------------------------------
// Squaring-mod random bytes: port checker
// Concurrent checks on the top-level channels, bound to the top level.
// ----------------------------------------------------------------------------
`include "squaring_mod_random_bytes_defines.svh"

module sqmrb_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_req_valid,
    input logic                         i_req_ready,
    input logic                         i_rsp_valid,
    input logic                         i_rsp_ready,
    input logic [sqmrb_pkg::BYTE_W-1:0] i_rsp_byte,
    input logic                         i_rsp_byte_valid,
    input logic                         i_rsp_status,
    input logic                         i_rsp_last
);

    `SQMRB_ASSERT_NXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_rsp_byte) && $stable(i_rsp_byte_valid) && $stable(i_rsp_status) && $stable(i_rsp_last), "response beat changed while stalled")
    `SQMRB_ASSERT_NOW(a_denied_no_byte, i_clk, i_rst_n, i_rsp_valid && (i_rsp_status == sqmrb_pkg::ST_DENIED), !i_rsp_byte_valid && (i_rsp_byte == '0), "refused request carries a byte")
    `SQMRB_ASSERT_NOW(a_zero_when_none, i_clk, i_rst_n, i_rsp_valid && !i_rsp_byte_valid, i_rsp_byte == '0, "byte not zero without a generated byte")
    `SQMRB_ASSERT_NXT(a_busy_after_req, i_clk, i_rst_n, i_req_valid && i_req_ready, !i_req_ready, "second request taken while one is in flight")

endmodule

bind squaring_mod_random_bytes sqmrb_checker u_sqmrb_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_req_valid      (i_req.valid),
    .i_req_ready      (i_req.ready),
    .i_rsp_valid      (o_rsp.valid),
    .i_rsp_ready      (o_rsp.ready),
    .i_rsp_byte       (o_rsp.random_byte),
    .i_rsp_byte_valid (o_rsp.byte_valid),
    .i_rsp_status     (o_rsp.status),
    .i_rsp_last       (o_rsp.last_out)
);

>>> tb/sv/sqmrb_byte_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Squaring-mod random bytes: response checker
// Follows seed writes and accepted requests, tracks the generator value on its
// own, works out the beat each request owes and compares every response beat,
// field by field, against the oldest beat still owed.
// ----------------------------------------------------------------------------
module sqmrb_byte_checker
    import sqmrb_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    sqmrb_cfg_if  i_cfg,
    sqmrb_req_if  i_req,
    sqmrb_rsp_if  i_rsp,
    output int    o_fail_count,
    output int    o_pending,
    output int    o_checked
);

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [BYTE_W-1:0] random_byte;
        logic              byte_valid;
        logic              status;
        logic              last_out;
    } t_rsp_beat;

    logic [SEED_W-1:0] gen_state = SEED_RESET;
    t_rsp_beat         owed_beats[$];
    int                fail_count = 0;
    int                checked = 0;

    function automatic logic [SEED_W-1:0] mod_square(input logic [SEED_W-1:0] v);
        logic [63:0] wide;
        wide = 64'(v) * 64'(v);
        return SEED_W'(wide % 64'(SQ_MOD));
    endfunction

    function automatic t_rsp_beat serve_request(
        input logic [FUNC_W-1:0] func,
        input logic              from_user,
        input logic [DCNT_W-1:0] discard_count,
        input logic              last
    );
        t_rsp_beat         beat;
        logic [SEED_W-1:0] v;
        longint unsigned   left;
        beat.random_byte = '0;
        beat.byte_valid  = 1'b0;
        beat.status      = ST_OK;
        beat.last_out    = last;
        if (func == FN_GET || func == FN_GET_KERNEL) begin
            if (func == FN_GET_KERNEL && from_user) begin
                beat.status = ST_DENIED;
            end else begin
                v = mod_square(gen_state);
                beat.random_byte[3:0] = v[3:0];
                v = mod_square(v);
                beat.random_byte[7:4] = v[3:0];
                gen_state = v;
                beat.byte_valid = 1'b1;
            end
        end else if (func == FN_DISCARD) begin
            left = 64'(discard_count) & ((64'd1 << COUNT_BITS) - 64'd1);
            v = gen_state;
            while (left != 0) begin
                v = mod_square(mod_square(v));
                left--;
            end
            gen_state = v;
        end
        return beat;
    endfunction

    always @(posedge i_clk) begin : watch
        t_rsp_beat want;
        t_rsp_beat got;
        if (!i_rst_n) begin
            gen_state = SEED_RESET;
            owed_beats.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                got.random_byte = i_rsp.random_byte;
                got.byte_valid  = i_rsp.byte_valid;
                got.status      = i_rsp.status;
                got.last_out    = i_rsp.last_out;
                checked++;
                if (owed_beats.size() == 0) begin
                    if (fail_count < MAX_REPORTS) begin
                        $display("%0t: response beat with no request owed: byte %02h valid %b",
                                 $time, got.random_byte, got.byte_valid);
                    end
                    fail_count++;
                end else begin
                    want = owed_beats.pop_front();
                    if (got.random_byte !== want.random_byte ||
                        got.byte_valid !== want.byte_valid ||
                        got.status !== want.status ||
                        got.last_out !== want.last_out) begin
                        if (fail_count < MAX_REPORTS) begin
                            $write("%0t: mismatch: expected byte %02h valid %b status %b last %b,",
                                   $time, want.random_byte, want.byte_valid, want.status,
                                   want.last_out);
                            $display(" got byte %02h valid %b status %b last %b",
                                     got.random_byte, got.byte_valid, got.status,
                                     got.last_out);
                        end
                        fail_count++;
                    end
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                gen_state = i_cfg.data;
            end
            if (i_req.valid && i_req.ready) begin
                owed_beats.push_back(serve_request(i_req.func, i_req.from_user,
                                                   i_req.discard_count, i_req.last));
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= owed_beats.size();
        o_checked    <= checked;
    end

endmodule

>>> tb/sv/tb_squaring_mod_random_bytes.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Squaring-mod random bytes: testbench top
// Writes seeds between phases, offers byte, kernel-only, discard and unused
// requests in random bursts against a stalling response sink, and gives the verdict
// from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module tb_squaring_mod_random_bytes;
    import sqmrb_pkg::*;

    localparam int                COUNT_BITS   = 16;
    localparam logic [FUNC_W-1:0] FN_UNUSED    = 2'd3;
    localparam int                CYCLE_LIMIT  = 8_000_000;
    localparam int                LONG_HOLD    = 400;
    localparam int                HOLD_AFTER   = 300;
    localparam int                PHASES       = 8;
    localparam int                PHASE_ITEMS  = 200;
    localparam int                DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              from_user;
        logic [DCNT_W-1:0] discard_count;
        logic              last;
    } t_byte_req;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_PERIODIC
    } t_rx_mode;

    logic            i_clk;
    logic            i_rst_n;
    int              fail_count;
    int              pending;
    int              checked;
    int              cycle_count = 0;
    int              burst_left = 0;
    int              n_get = 0;
    int              n_denied = 0;
    int              n_discard = 0;
    int              n_unused = 0;
    int              n_seeds = 0;
    longint unsigned n_skipped = 0;

    sqmrb_cfg_if cfg_ch ();
    sqmrb_req_if req_ch ();
    sqmrb_rsp_if rsp_ch ();

    squaring_mod_random_bytes #(
        .COUNT_BITS (COUNT_BITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    sqmrb_byte_checker #(
        .COUNT_BITS (COUNT_BITS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg_ch),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Run stopped by timeout after %0d cycles", cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    function automatic t_byte_req mk_req(
        input logic [FUNC_W-1:0] func,
        input logic              from_user,
        input logic [DCNT_W-1:0] count,
        input logic              last
    );
        t_byte_req r;
        r.func          = func;
        r.from_user     = from_user;
        r.discard_count = count;
        r.last          = last;
        return r;
    endfunction

    task automatic put_req(input t_byte_req r);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        case (r.func)
            FN_GET: n_get++;
            FN_GET_KERNEL: begin
                if (r.from_user) n_denied++;
                else n_get++;
            end
            FN_DISCARD: begin
                n_discard++;
                n_skipped += r.discard_count;
            end
            default: n_unused++;
        endcase
        req_ch.valid         <= 1'b1;
        req_ch.func          <= r.func;
        req_ch.from_user     <= r.from_user;
        req_ch.discard_count <= r.discard_count;
        req_ch.last          <= r.last;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    task automatic write_seed(input logic [SEED_W-1:0] value);
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        n_seeds++;
        burst_left = 0;
    endtask

    initial begin : rsp_drive
        int       seg_left;
        int       period;
        int       stall_len;
        int       step;
        int       hold_left;
        bit       hold_done;
        t_rx_mode mode;
        seg_left  = 0;
        period    = 2;
        stall_len = 1;
        step      = 0;
        hold_left = 0;
        hold_done = 1'b0;
        mode      = RX_OPEN;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!hold_done && checked >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                if (seg_left == 0) begin
                    seg_left  = $urandom_range(16, 160);
                    mode      = t_rx_mode'($urandom_range(0, 2));
                    period    = $urandom_range(2, 16);
                    stall_len = $urandom_range(1, period - 1);
                    step      = 0;
                end
                seg_left--;
                case (mode)
                    RX_OPEN: rsp_ch.ready <= 1'b1;
                    RX_COIN: rsp_ch.ready <= 1'($urandom_range(0, 1));
                    default: begin
                        rsp_ch.ready <= (step >= stall_len);
                        step = (step + 1) % period;
                    end
                endcase
            end
        end
    end

    initial begin : stimulus
        int                phase_idx;
        int                sent;
        int                run_len;
        int                pick;
        logic [FUNC_W-1:0] f;
        logic              u;
        logic [SEED_W-1:0] phase_seeds [PHASES];
        i_rst_n              <= 1'b0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.data          <= '0;
        req_ch.valid         <= 1'b0;
        req_ch.func          <= FN_GET;
        req_ch.from_user     <= 1'b0;
        req_ch.discard_count <= '0;
        req_ch.last          <= 1'b0;
        phase_seeds[0] = $urandom();
        phase_seeds[1] = 32'(SQ_MOD) + 32'd1;
        phase_seeds[2] = 32'd1;
        phase_seeds[3] = $urandom();
        phase_seeds[4] = 32'hFFFF_FFFF;
        phase_seeds[5] = $urandom();
        phase_seeds[6] = 32'(SQ_MOD) - 32'd1;
        phase_seeds[7] = SEED_RESET;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset seed: every operation, refused kernel request, zero, one and full discard
        put_req(mk_req(FN_GET,        1'b0, 16'h0000, 1'b0));
        put_req(mk_req(FN_GET,        1'b1, 16'hFFFF, 1'b1));
        put_req(mk_req(FN_GET_KERNEL, 1'b0, 16'h0000, 1'b1));
        put_req(mk_req(FN_GET_KERNEL, 1'b1, 16'hFFFF, 1'b0));
        put_req(mk_req(FN_DISCARD,    1'b0, 16'h0000, 1'b1));
        put_req(mk_req(FN_DISCARD,    1'b1, 16'h0001, 1'b0));
        put_req(mk_req(FN_UNUSED,     1'b1, 16'hFFFF, 1'b1));
        put_req(mk_req(FN_GET,        1'b0, 16'h5A5A, 1'b1));
        put_req(mk_req(FN_DISCARD,    1'b0, 16'hFFFF, 1'b1));
        put_req(mk_req(FN_GET_KERNEL, 1'b0, 16'hA5A5, 1'b0));

        // seeds at and above the modulus, then the all-zero seed
        write_seed(32'hFFFF_FFFF);
        put_req(mk_req(FN_GET_KERNEL, 1'b1, 16'h0000, 1'b0));
        put_req(mk_req(FN_GET,        1'b0, 16'h0000, 1'b1));
        write_seed(32'hFFFF_FFFF);
        put_req(mk_req(FN_DISCARD,    1'b0, 16'h0001, 1'b1));
        put_req(mk_req(FN_GET,        1'b0, 16'h0000, 1'b1));
        write_seed(32'(SQ_MOD));
        put_req(mk_req(FN_GET_KERNEL, 1'b0, 16'h0000, 1'b0));
        put_req(mk_req(FN_GET,        1'b1, 16'h0000, 1'b1));
        write_seed('0);
        put_req(mk_req(FN_GET,        1'b0, 16'h0000, 1'b1));
        put_req(mk_req(FN_DISCARD,    1'b0, 16'h0003, 1'b1));
        put_req(mk_req(FN_GET,        1'b0, 16'h0000, 1'b1));

        for (phase_idx = 0; phase_idx < PHASES; phase_idx++) begin
            write_seed(phase_seeds[phase_idx]);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                pick = $urandom_range(0, 9);
                if (pick < 6) begin
                    run_len = $urandom_range(1, 8);
                    f = $urandom_range(0, 1) ? FN_GET_KERNEL : FN_GET;
                    u = 1'($urandom_range(0, 1));
                    for (int i = 0; i < run_len; i++) begin
                        put_req(mk_req(f, u, 16'($urandom()), i == run_len - 1));
                    end
                    sent += run_len;
                end else if (pick < 9) begin
                    put_req(mk_req(FN_DISCARD, 1'($urandom_range(0, 1)),
                                   ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 63))
                                                               : 16'($urandom_range(0, 15)),
                                   1'b1));
                    sent++;
                end else begin
                    f = FUNC_W'($urandom_range(0, 3));
                    put_req(mk_req(f, 1'($urandom_range(0, 1)),
                                   (f == FN_DISCARD) ? 16'($urandom_range(0, 7))
                                                     : 16'($urandom()),
                                   1'($urandom_range(0, 1))));
                    if (f != FN_UNUSED) sent++;
                end
            end
        end

        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Covered %0d byte requests, %0d refused kernel-only, %0d discards (%0d bytes) and %0d unused selectors.",
                 n_get, n_denied, n_discard, n_skipped, n_unused);
        $display("Wrote %0d seed settings; %0d response beats checked, %0d failures.",
                 n_seeds, checked, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
